/* hdl/cfe_pkg.sv */
`default_nettype none

package cfe_pkg;

  // Item kinds
  localparam logic [2:0] KIND_COUNT    = 3'd0;
  localparam logic [2:0] KIND_UNSIGNED = 3'd1;
  localparam logic [2:0] KIND_SIGNED   = 3'd2;
  localparam logic [2:0] KIND_STR_HDR  = 3'd3;
  localparam logic [2:0] KIND_STR_BYTE = 3'd4;

  // Header byte fields
  localparam logic [7:0] HDR_LAST   = 8'h80;
  localparam logic [7:0] HDR_STRING = 8'h40;
  localparam logic [7:0] HDR_SIGNED = 8'h20;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] field_value;
    logic        last_field;
    logic [5:0]  string_length;
    logic [7:0]  char_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } out_item_t;

  // Classified work for the serializer: one lead byte, then nval value bytes
  typedef struct packed {
    logic [7:0]  head;
    logic [31:0] value;
    logic [2:0]  nval;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

/* hdl/cfe_front.sv */
`default_nettype none

module cfe_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cfe_pkg::in_item_t in_data,
  input  wire cfe_pkg::q_stat_t  q_stat,
  output logic                   q_push,
  output cfe_pkg::cmd_t          q_wdata
);
  import cfe_pkg::*;

  logic [7:0] flag;
  logic [2:0] usize;
  logic [2:0] ssize;
  logic       kind_ok;
  logic [31:0] v;

  assign v    = in_data.field_value;
  assign flag = in_data.last_field ? HDR_LAST : 8'h00;

  always_comb begin
    if (v[31:8] == 24'd0) begin
      usize = 3'd1;
    end else if (v[31:16] == 16'd0) begin
      usize = 3'd2;
    end else if (v[31:24] == 8'd0) begin
      usize = 3'd3;
    end else begin
      usize = 3'd4;
    end
  end

  // Minimal two's complement width: all bits above the top kept bit equal the sign
  always_comb begin
    if ((v[31:7] == 25'd0) || (v[31:7] == {25{1'b1}})) begin
      ssize = 3'd1;
    end else if ((v[31:15] == 17'd0) || (v[31:15] == {17{1'b1}})) begin
      ssize = 3'd2;
    end else if ((v[31:23] == 9'd0) || (v[31:23] == {9{1'b1}})) begin
      ssize = 3'd3;
    end else begin
      ssize = 3'd4;
    end
  end

  always_comb begin
    kind_ok       = 1'b1;
    q_wdata.value = v;
    q_wdata.nval  = 3'd0;
    q_wdata.head  = 8'h00;
    unique case (in_data.kind)
      KIND_COUNT: begin
        q_wdata.head = v[7:0];
      end
      KIND_UNSIGNED: begin
        q_wdata.head = flag | {5'd0, usize};
        q_wdata.nval = usize;
      end
      KIND_SIGNED: begin
        q_wdata.head = flag | HDR_SIGNED | {5'd0, ssize};
        q_wdata.nval = ssize;
      end
      KIND_STR_HDR: begin
        q_wdata.head = flag | HDR_STRING | {2'b00, in_data.string_length};
      end
      KIND_STR_BYTE: begin
        q_wdata.head = in_data.char_byte;
      end
      default: begin
        kind_ok = 1'b0;
      end
    endcase
  end

  // Unused kinds are taken and dropped
  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full && kind_ok;

endmodule

`default_nettype wire

/* hdl/cfe_queue.sv */
`default_nettype none

module cfe_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cfe_pkg::cmd_t    wdata,
  input  wire logic             pop,
  output cfe_pkg::cmd_t         rdata,
  output cfe_pkg::q_stat_t      stat
);
  import cfe_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CW'(DEPTH));

endmodule

`default_nettype wire

/* hdl/cfe_back.sv */
`default_nettype none

module cfe_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfe_pkg::q_stat_t   q_stat,
  input  wire cfe_pkg::cmd_t      q_rdata,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfe_pkg::out_item_t      out_data
);
  import cfe_pkg::*;

  logic        cur_valid_r, cur_valid_nxt;
  logic        hdr_pend_r, hdr_pend_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [31:0] val_r, val_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        can_emit;
  logic        emit;
  logic        emit_last;
  out_item_t   emit_item;

  assign can_emit = !out_valid_r || out_ready;
  assign emit     = cur_valid_r && can_emit;

  always_comb begin
    if (hdr_pend_r) begin
      emit_item.out_byte = head_r;
      emit_item.run_end  = (rem_r == 3'd0);
    end else begin
      emit_item.out_byte = val_r[7:0];
      emit_item.run_end  = (rem_r == 3'd1);
    end
  end

  assign emit_last = emit && emit_item.run_end;
  // Load the next command as soon as the current one sends its final byte
  assign q_pop     = !q_stat.empty && (!cur_valid_r || emit_last);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    hdr_pend_nxt  = hdr_pend_r;
    head_nxt      = head_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
      if (hdr_pend_r) begin
        hdr_pend_nxt = 1'b0;
      end else begin
        val_nxt = {8'h00, val_r[31:8]};
        rem_nxt = rem_r - 3'd1;
      end
      if (emit_item.run_end) begin
        cur_valid_nxt = 1'b0;
      end
    end

    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      hdr_pend_nxt  = 1'b1;
      head_nxt      = q_rdata.head;
      val_nxt       = q_rdata.value;
      rem_nxt       = q_rdata.nval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_pend_r <= hdr_pend_nxt;
    head_r     <= head_nxt;
    val_r      <= val_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/compact_field_encoder.sv */
`default_nettype none

// Channel   Direction  Payload     Handshake
// in_       input      in_item_t   in_valid / in_ready
// out_      output     out_item_t  out_valid / out_ready
//
// A count, string header or string byte transaction yields one byte; a number yields
// a header byte plus 1 to 4 value bytes. The serializer emits one byte per cycle while
// the output is not stalled; the command queue lets the classifier keep taking
// transactions, until it is full, while the serializer is busy or the output is stalled.
// The first byte passes through the queue, the command registers and the output register.
// Synchronous reset clears the queue and all valid flags; no clearing pass is needed.

module compact_field_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cfe_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfe_pkg::out_item_t      out_data
);
  import cfe_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    q_wdata;
  cmd_t    q_rdata;

  cfe_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  cfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  cfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.run_end) |=> out_valid)
    else $error("byte run broken before its final byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire
